@@ hdl/ddve_pkg.sv @@
`timescale 1ns / 1ps
package ddve_pkg;

  localparam int VAL_W   = 32;
  localparam int DIG_N   = 10;   // decimal digits of a 32-bit magnitude
  localparam int PLACE_W = 30;   // 10^9 fits
  localparam int EXT_W   = 36;   // headroom for value +/- 9 * 10^9

  localparam logic [3:0] KIND_UP       = 4'd0;
  localparam logic [3:0] KIND_FN_UP    = 4'd1;
  localparam logic [3:0] KIND_DOWN     = 4'd2;
  localparam logic [3:0] KIND_FN_DOWN  = 4'd3;
  localparam logic [3:0] KIND_LEFT     = 4'd4;
  localparam logic [3:0] KIND_FN_LEFT  = 4'd5;
  localparam logic [3:0] KIND_RIGHT    = 4'd6;
  localparam logic [3:0] KIND_FN_RIGHT = 4'd7;
  localparam logic [3:0] KIND_DIGIT    = 4'd8;

  localparam logic [1:0] REG_MIN  = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_PREC = 2'd2;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] digit;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [3:0]         cursor_out;
    logic [3:0]         digit_count;
    logic               handled;
  } out_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic mult;
    logic update;
    logic finish;
  } cmd_t;

  function automatic logic [PLACE_W-1:0] pow10(input logic [3:0] n);
    case (n)
      4'd0:    return 30'd1;
      4'd1:    return 30'd10;
      4'd2:    return 30'd100;
      4'd3:    return 30'd1000;
      4'd4:    return 30'd10000;
      4'd5:    return 30'd100000;
      4'd6:    return 30'd1000000;
      4'd7:    return 30'd10000000;
      4'd8:    return 30'd100000000;
      default: return 30'd1000000000;
    endcase
  endfunction

  // decimal digits of |v|, at least precision plus 1, capped at DIG_N
  function automatic logic [3:0] count_digits(input logic signed [31:0] v,
                                              input logic [2:0] p);
    logic [31:0] mag;
    logic [3:0]  d;
    logic [3:0]  lo;
    mag = v[31] ? (~v + 32'd1) : v;
    d = 4'd1;
    for (int k = 1; k < DIG_N; k++) begin
      if (mag >= {2'b00, pow10(4'(k))}) d = d + 4'd1;
    end
    lo = {1'b0, p} + 4'd1;
    if (d < lo) d = lo;
    if (d > 4'(DIG_N)) d = 4'(DIG_N);
    return d;
  endfunction

endpackage

@@ hdl/ddve_ctrl.sv @@
`timescale 1ns / 1ps
module ddve_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ddve_pkg::cmd_t cmd
);
  import ddve_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_MUL, S_UPD, S_FIN, S_OUT
  } state_t;

  state_t     state_r;
  logic [4:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          cnt_r <= 5'd0;
          if (in_valid) state_r <= S_CONV;
        end
        S_CONV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_MUL;
        end
        S_MUL:  state_r <= S_UPD;
        S_UPD:  state_r <= S_FIN;
        S_FIN:  state_r <= S_OUT;
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.shift  = (state_r == S_CONV);
  assign cmd.mult   = (state_r == S_MUL);
  assign cmd.update = (state_r == S_UPD);
  assign cmd.finish = (state_r == S_FIN);

endmodule

@@ hdl/ddve_dp.sv @@
`timescale 1ns / 1ps
module ddve_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ddve_pkg::cmd_t     cmd,
  input  ddve_pkg::in_t      in_data,
  input  logic signed [31:0] min_val,
  input  logic signed [31:0] max_val,
  input  logic [2:0]         prec,
  output ddve_pkg::out_t     out_data
);
  import ddve_pkg::*;

  logic signed [31:0]        value_r;
  logic [3:0]                cursor_r;
  in_t                       key_r;
  logic [3:0]                total_r;
  logic [PLACE_W-1:0]        place_r;
  logic [31:0]               bin_r;
  logic [3:0]                bcd_r [DIG_N];
  logic signed [EXT_W-1:0]   change_r;
  out_t                      out_r;

  // small remainder x mod t, t >= 1
  function automatic logic [3:0] small_mod(input logic [4:0] x, input logic [3:0] t);
    logic [8:0] rem;
    logic [8:0] d;
    rem = {4'd0, x};
    for (int b = 4; b >= 0; b--) begin
      d = {5'd0, t} << b;
      if (rem >= d) rem = rem - d;
    end
    return rem[3:0];
  endfunction

  // double-dabble step
  logic [3:0] adj [DIG_N];
  logic [3:0] bcd_nxt [DIG_N];
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    for (int i = 0; i < DIG_N; i++) begin
      if (i == 0) bcd_nxt[i] = {adj[i][2:0], bin_r[31]};
      else        bcd_nxt[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // digit multiply
  logic [3:0]              cur_dig;
  logic [3:0]              typed;
  logic signed [4:0]       diff;
  logic signed [EXT_W-1:0] prod;
  always_comb begin
    cur_dig = (cursor_r < 4'(DIG_N)) ? bcd_r[cursor_r] : 4'd0;
    typed   = (key_r.digit > 4'd9) ? 4'd9 : key_r.digit;
    diff    = $signed({1'b0, typed}) - $signed({1'b0, cur_dig});
    prod    = EXT_W'(diff) * EXT_W'($signed({1'b0, place_r}));
  end

  // key update
  logic signed [EXT_W-1:0] v36, top36, bot36, pl36, val_nxt;
  logic [3:0]              cur_nxt;
  logic [3:0]              back_one;
  always_comb begin
    v36      = EXT_W'(value_r);
    top36    = EXT_W'(max_val);
    bot36    = EXT_W'(min_val);
    pl36     = EXT_W'({1'b0, place_r});
    val_nxt  = v36;
    cur_nxt  = cursor_r;
    back_one = (cursor_r == 4'd0) ? total_r - 4'd1 : cursor_r - 4'd1;
    case (key_r.kind)
      KIND_UP:       val_nxt = (top36 - pl36 <= v36) ? top36 : v36 + pl36;
      KIND_DOWN:     val_nxt = (bot36 + pl36 >= v36) ? bot36 : v36 - pl36;
      KIND_FN_UP:    val_nxt = top36;
      KIND_FN_DOWN:  val_nxt = bot36;
      KIND_LEFT:     cur_nxt = small_mod({1'b0, cursor_r} + 5'd1, total_r);
      KIND_FN_LEFT:  cur_nxt = total_r - 4'd1;
      KIND_RIGHT:    cur_nxt = back_one;
      KIND_FN_RIGHT: cur_nxt = 4'd0;
      KIND_DIGIT: begin
        cur_nxt = back_one;
        if (change_r >= 0) begin
          val_nxt = (change_r > top36 - v36) ? top36 : v36 + change_r;
        end else begin
          val_nxt = (-change_r > v36 - bot36) ? bot36 : v36 + change_r;
        end
      end
      default: ;
    endcase
  end

  // closing count and top-digit cursor fix for steps
  logic [3:0] new_cnt;
  logic       is_step;
  logic [3:0] cur_fin;
  always_comb begin
    new_cnt = count_digits(value_r, prec);
    is_step = (key_r.kind == KIND_UP) || (key_r.kind == KIND_DOWN);
    cur_fin = cursor_r;
    if (is_step && (total_r > new_cnt) && (cursor_r == total_r - 4'd1) &&
        (cursor_r != 4'd0)) begin
      cur_fin = cursor_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r  <= 32'sd0;
      cursor_r <= 4'd0;
    end else begin
      if (cmd.update) begin
        value_r  <= 32'(val_nxt);
        cursor_r <= cur_nxt;
      end
      if (cmd.finish) cursor_r <= cur_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= in_data;
      total_r <= count_digits(value_r, prec);
      place_r <= pow10(cursor_r);
      bin_r   <= value_r[31] ? (~value_r + 32'd1) : value_r;
      for (int i = 0; i < DIG_N; i++) bcd_r[i] <= 4'd0;
    end
    if (cmd.shift) begin
      bin_r <= {bin_r[30:0], 1'b0};
      for (int i = 0; i < DIG_N; i++) bcd_r[i] <= bcd_nxt[i];
    end
    if (cmd.mult) change_r <= value_r[31] ? -prod : prod;
    if (cmd.finish) begin
      out_r.value_out   <= value_r;
      out_r.cursor_out  <= cur_fin;
      out_r.digit_count <= new_cnt;
      out_r.handled     <= (key_r.kind <= KIND_DIGIT);
    end
  end

  assign out_data = out_r;

endmodule

@@ hdl/decimal_digit_value_editor.sv @@
`timescale 1ns / 1ps
// A request is accepted, then passes through 32 BCD conversion steps, digit
//   multiply, update and digit count before out_valid.
// One request is in flight at a time: a new request is accepted only after the
//   result is taken; the 32-step binary-to-BCD converter is the longest part.
// Reset (rst_n low, sync): value 0, cursor 0, limits -2^31 / 2^31-1, precision 0.
module decimal_digit_value_editor (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ddve_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ddve_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import ddve_pkg::*;

  // APB register file: minimum at 0x0, maximum at 0x4, precision at 0x8
  logic signed [31:0] min_r;
  logic signed [31:0] max_r;
  logic [2:0]         prec_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= 32'sh8000_0000;
      max_r  <= 32'sh7FFF_FFFF;
      prec_r <= 3'd0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MIN:  min_r  <= pwdata;
        REG_MAX:  max_r  <= pwdata;
        REG_PREC: prec_r <= pwdata[2:0];
        default: ;  // unmapped, dropped
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN:  prdata = min_r;
      REG_MAX:  prdata = max_r;
      REG_PREC: prdata = {29'd0, prec_r};
      default:  prdata = 32'd0;
    endcase
  end

  // sequencer: walks each request through load, convert, multiply, update, finish, output
  cmd_t cmd;

  ddve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: value/cursor state, BCD digit extraction, clamp arithmetic;
  // result held in an output register until taken
  ddve_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .min_val  (min_r),
    .max_val  (max_r),
    .prec     (prec_r),
    .out_data (out_data)
  );

endmodule

@@ tb/decimal_digit_value_editor_test.sv @@
`timescale 1ns / 1ps
module decimal_digit_value_editor_test;
  import ddve_pkg::*;

  localparam int MAX_CYCLES = 1000000;
  localparam int SETTLE = 40;  // block latency plus margin
  localparam longint LIM_LO = -64'sd2147483648;
  localparam longint LIM_HI = 64'sd2147483647;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  decimal_digit_value_editor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Editor state as the testbench sees it
  longint edit_value;
  int     edit_cursor;
  longint lim_min;
  longint lim_max;
  int     frac_digits;

  out_t   expected_edits[$];
  int     errors;
  int     cycles;
  int     hold_len;   // one-shot long stall for the receiver

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("[decimal_digit_value_editor] ERROR");
      $finish;
    end
  end

  function automatic longint pow_ten(int n);
    longint p;
    p = 1;
    for (int i = 0; i < n && i < 18; i++) p = p * 10;
    return p;
  endfunction

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // integer digits of |v| plus fractional digits, capped at DIG_N
  function automatic int shown_digits(longint v);
    longint ip;
    int n;
    int total;
    ip = mag_of(v) / pow_ten(frac_digits);
    n = 1;
    while (ip >= 10 && n < DIG_N) begin
      ip = ip / 10;
      n++;
    end
    total = n + frac_digits;
    if (total > DIG_N) total = DIG_N;
    return total;
  endfunction

  // Apply one key to the tracked state, return the expected result
  function automatic out_t edit_key(logic [3:0] kind, logic [3:0] digit);
    out_t   r;
    int     total;
    int     nt;
    longint v;
    longint place;
    longint cur;
    longint change;
    int     dg;
    total = shown_digits(edit_value);
    v = edit_value;
    place = pow_ten(edit_cursor);
    r.handled = 1'b1;
    case (kind)
      KIND_UP, KIND_DOWN: begin
        if (kind == KIND_UP) v = (lim_max - place <= v) ? lim_max : v + place;
        else v = (lim_min + place >= v) ? lim_min : v - place;
        nt = shown_digits(v);
        // top digit vanished: cursor follows it down
        if (total > nt && edit_cursor == total - 1 && edit_cursor != 0)
          edit_cursor--;
      end
      KIND_FN_UP:    v = lim_max;
      KIND_FN_DOWN:  v = lim_min;
      KIND_LEFT:     edit_cursor = (edit_cursor + 1) % total;
      KIND_FN_LEFT:  edit_cursor = total - 1;
      KIND_RIGHT:    edit_cursor = (edit_cursor == 0) ? total - 1 : edit_cursor - 1;
      KIND_FN_RIGHT: edit_cursor = 0;
      KIND_DIGIT: begin
        dg = (digit > 9) ? 9 : int'(digit);
        cur = (mag_of(v) / place) % 10;
        change = (longint'(dg) - cur) * place;
        // negative value: the digit replaces the magnitude's digit
        if (v < 0) change = -change;
        if (change >= 0) v = (change > lim_max - v) ? lim_max : v + change;
        else v = (-change > v - lim_min) ? lim_min : v + change;
        edit_cursor = (edit_cursor == 0) ? total - 1 : edit_cursor - 1;
      end
      default: r.handled = 1'b0;
    endcase
    edit_value = longint'($signed(v[31:0]));
    edit_cursor = edit_cursor & 15;
    r.value_out = edit_value[31:0];
    r.cursor_out = edit_cursor[3:0];
    r.digit_count = 4'(shown_digits(edit_value));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_edits.size() == 0) begin
        report_mismatch("unexpected result", out_data.value_out, 0);
      end else begin
        e = expected_edits.pop_front();
        if (out_data.value_out !== e.value_out)
          report_mismatch("value_out", $signed(out_data.value_out), $signed(e.value_out));
        if (out_data.cursor_out !== e.cursor_out)
          report_mismatch("cursor_out", out_data.cursor_out, e.cursor_out);
        if (out_data.digit_count !== e.digit_count)
          report_mismatch("digit_count", out_data.digit_count, e.digit_count);
        if (out_data.handled !== e.handled)
          report_mismatch("handled", out_data.handled, e.handled);
      end
    end
  end

  // Receiver: random stall per result, plus an occasional long hold-off
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Send one key request; entered and left at a falling edge
  task automatic send_key(logic [3:0] kind, logic [3:0] digit);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.kind = kind;
    in_data.digit = digit;
    do @(posedge clk); while (!in_ready);
    expected_edits.push_back(edit_key(kind, digit));
    @(negedge clk);
  endtask

  // Drain all outstanding results, then let the block settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_edits.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_MIN:  lim_min = longint'($signed(val));
      REG_MAX:  lim_max = longint'($signed(val));
      REG_PREC: frac_digits = int'(val[2:0]);
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_limits(longint lo, longint hi, int prec);
    wait_idle();
    write_reg(REG_MIN, lo[31:0]);
    write_reg(REG_MAX, hi[31:0]);
    write_reg(REG_PREC, prec[31:0]);
  endtask

  function automatic longint pick_limit();
    case ($urandom_range(0, 5))
      0: return LIM_LO;
      1: return LIM_HI;
      2: return 0;
      3: return longint'($urandom_range(0, 200000)) - 100000;
      4: return longint'($urandom_range(0, 2000)) - 1000;
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  // Every key kind, including undefined ones, with boundary digits
  task automatic test_every_key();
    for (int k = 0; k < 16; k++) send_key(k[3:0], (k == 8) ? 4'd15 : k[3:0]);
  endtask

  // Saturation at the 32-bit extremes and typing into the most negative value
  task automatic test_extremes();
    send_key(KIND_FN_UP, 4'd0);
    send_key(KIND_FN_LEFT, 4'd0);
    send_key(KIND_UP, 4'd0);
    send_key(KIND_FN_DOWN, 4'd0);
    send_key(KIND_DIGIT, 4'd9);
    send_key(KIND_DIGIT, 4'd0);
    send_key(KIND_DOWN, 4'd0);
    send_key(KIND_FN_RIGHT, 4'd0);
  endtask

  // Seven fractional digits and a minimum above the maximum
  task automatic test_odd_config();
    set_limits(500, -500, 7);
    send_key(KIND_UP, 4'd0);
    send_key(KIND_DOWN, 4'd0);
    send_key(KIND_DIGIT, 4'd5);
    send_key(KIND_LEFT, 4'd0);
    // cursor left beyond the digit count after the value shrinks
    set_limits(-99999, 99999, 0);
    send_key(KIND_FN_UP, 4'd0);
    send_key(KIND_FN_LEFT, 4'd0);
    send_key(KIND_FN_DOWN, 4'd0);
    send_key(KIND_UP, 4'd0);
    send_key(KIND_DOWN, 4'd0);
  endtask

  // Receiver holds off long enough for the sender to be stalled
  task automatic test_backpressure();
    hold_len = 600;
    for (int i = 0; i < 8; i++) send_key(4'($urandom_range(0, 8)), 4'($urandom_range(0, 15)));
  endtask

  // Random keys under varied limits; mostly well-formed edits
  task automatic test_random_edits(int items);
    logic [3:0] kind;
    longint lo;
    longint hi;
    longint t;
    int done;
    done = 0;
    while (done < items) begin
      lo = pick_limit();
      hi = pick_limit();
      if (lo > hi && $urandom_range(0, 7) != 0) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      set_limits(lo, hi, $urandom_range(0, 7));
      repeat (150) begin
        case ($urandom_range(0, 9))
          0, 1, 2: kind = KIND_DIGIT;
          3, 4:    kind = $urandom_range(0, 1) ? KIND_UP : KIND_DOWN;
          5, 6:    kind = $urandom_range(0, 1) ? KIND_LEFT : KIND_RIGHT;
          7:       kind = 4'($urandom_range(KIND_FN_UP, KIND_FN_RIGHT));
          8:       kind = 4'($urandom_range(0, 15));
          default: kind = 4'($urandom_range(KIND_UP, KIND_DIGIT));
        endcase
        send_key(kind, 4'($urandom_range(0, 15)));
        done++;
      end
    end
  endtask

  initial begin
    errors = 0;
    hold_len = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    edit_value = 0;
    edit_cursor = 0;
    lim_min = LIM_LO;
    lim_max = LIM_HI;
    frac_digits = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_every_key();
    test_extremes();
    test_odd_config();
    test_backpressure();
    test_random_edits(1900);
    set_limits(LIM_LO, LIM_HI, 0);
    send_key(KIND_FN_UP, 4'd0);

    wait_idle();
    if (errors == 0) begin
      $display("[decimal_digit_value_editor] OK");
    end else begin
      $display("[decimal_digit_value_editor] ERROR");
    end
    $finish;
  end

endmodule
